// File: hw/rtl/ppd_pkg.sv
// Shared constants, types and helpers for the palette pixel doubler.
package ppd_pkg;

	localparam int SRC_WIDTH  = 320;
	localparam int SRC_HEIGHT = 200;

	localparam int COL_W  = 9;
	localparam int ROW_W  = 8;
	localparam int IDX_W  = 8;
	localparam int COMP_W = 8;
	localparam int ADDR_W = 18;

	localparam int DST_WIDTH  = 2 * SRC_WIDTH;
	localparam int ROW_STRIDE = 2 * DST_WIDTH;

	localparam int PAL_DEPTH = 256;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 48;

	typedef logic [1:0] beat_t;
	localparam beat_t BEAT_FIRST = 2'd0;
	localparam beat_t BEAT_LAST  = 2'd3;

	typedef struct packed {
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		rgb_t              rgb;
	} pix_t;

	// Offset of each beat inside the 2x2 block.
	function automatic logic [ADDR_W-1:0] beat_offset(input beat_t beat);
		logic [ADDR_W-1:0] off;
		case (beat)
			2'd0:    off = '0;
			2'd1:    off = ADDR_W'(1);
			2'd2:    off = ADDR_W'(DST_WIDTH);
			default: off = ADDR_W'(DST_WIDTH + 1);
		endcase
		return off;
	endfunction

endpackage

// File: hw/rtl/ppd_expander.sv
// Output stage: expands one looked-up pixel into four transfers of a 2x2 block.
module ppd_expander (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	input  ppd_pkg::pix_t                     pix,
	output logic                              pix_ready,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [ppd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // dest_address, red, green, blue
	output logic                              m_axis_tlast
);
	import ppd_pkg::*;

	logic              vld_q;
	beat_t             beat_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] addr_q;
	rgb_t              rgb_q;
	logic              done;
	logic              load;
	beat_t             beat_nxt;

	assign done     = !vld_q || (m_axis_tready && beat_q == BEAT_LAST);
	assign load     = pix_valid && done;
	assign beat_nxt = beat_q + beat_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			beat_q <= BEAT_FIRST;
		end else if (load) begin
			vld_q  <= 1'b1;
			beat_q <= BEAT_FIRST;
		end else if (done) begin
			vld_q  <= 1'b0;
		end else if (m_axis_tready) begin
			beat_q <= beat_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			base_q <= pix.base;
			addr_q <= pix.base;
			rgb_q  <= pix.rgb;
		end else if (vld_q && m_axis_tready && beat_q != BEAT_LAST) begin
			addr_q <= base_q + beat_offset(beat_nxt);
		end
	end

	assign pix_ready     = done;
	assign m_axis_tvalid = vld_q;
	assign m_axis_tlast  = (beat_q == BEAT_LAST);
	assign m_axis_tdata  = {(OUT_DATA_W - ADDR_W - 3*COMP_W)'(0),
	                        rgb_q.blue, rgb_q.green, rgb_q.red, addr_q};

`ifndef SYNTH
	a_beat_steps: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && m_axis_tready && beat_q != BEAT_LAST
		|=> vld_q && beat_q == $past(beat_nxt))
		else $error("beat counter did not advance on transfer");

	a_last_addr: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && beat_q == BEAT_LAST |-> addr_q == base_q + ADDR_W'(DST_WIDTH + 1))
		else $error("last beat address off the block");

	a_load_first: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> vld_q && beat_q == BEAT_FIRST && addr_q == base_q)
		else $error("new block did not start at its base");
`endif

endmodule

// File: hw/rtl/palette_pixel_doubler.sv
// Top level of the palette pixel doubler: input stage, palette memory, address stage.
//
// Each input transfer is either a palette write (tuser = 1) or a source pixel
// (tuser = 0). A palette write gives no output; it is seen by every pixel
// accepted after it. A pixel inside the 320x200 source is looked up and leaves
// as four output transfers, the 2x2 block it covers in the 640x400 frame, the
// fourth with tlast set; a pixel outside the source is dropped. Output moves one
// transfer per cycle while tready is high; a pixel loads as the last transfer of
// the one before leaves. Writes go one per cycle unless a pixel stalls stage 1.
// Stages: input register, palette read, address add, output register. A pixel
// reading an entry never written since reset gives an undefined color.
module palette_pixel_doubler (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [ppd_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // column, row, color_index, red, green, blue
	input  logic [0:0]                       s_axis_tuser,  // mode
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [ppd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // dest_address, red, green, blue
	output logic                             m_axis_tlast
);
	import ppd_pkg::*;

	// input field unpacking
	logic [COL_W-1:0]  in_col;
	logic [ROW_W-1:0]  in_row;
	logic [IDX_W-1:0]  in_idx;
	rgb_t              in_rgb;
	logic              in_wr;
	logic              in_acc;
	logic              in_keep;

	assign in_col       = s_axis_tdata[8:0];
	assign in_row       = s_axis_tdata[16:9];
	assign in_idx       = s_axis_tdata[24:17];
	assign in_rgb.red   = s_axis_tdata[32:25];
	assign in_rgb.green = s_axis_tdata[40:33];
	assign in_rgb.blue  = s_axis_tdata[48:41];
	assign in_wr        = s_axis_tuser[0];

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign in_keep = in_wr || (in_col < COL_W'(SRC_WIDTH) && in_row < ROW_W'(SRC_HEIGHT));

	// stage 1: registered input
	logic              valid_s1;
	logic              wr_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [IDX_W-1:0]  idx_s1;
	rgb_t              rgb_s1;

	// stage 2: palette data, row offset
	logic              valid_s2;
	rgb_t              rgb_s2;
	logic [ADDR_W-1:0] row_off_s2;
	logic [COL_W:0]    col2_s2;

	// stage 3: block base address
	logic              valid_s3;
	pix_t              pix_s3;

	logic adv_s1;
	logic ready_s2;
	logic ready_s3;
	logic pix_ready;

	rgb_t palette_mem [PAL_DEPTH];

	// writes retire at stage 1 and never wait on downstream
	assign adv_s1        = valid_s1 && (wr_s1 || ready_s2);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign ready_s3      = !valid_s3 || pix_ready;
	assign ready_s2      = !valid_s2 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= in_keep;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			wr_s1  <= in_wr;
			col_s1 <= in_col;
			row_s1 <= in_row;
			idx_s1 <= in_idx;
			rgb_s1 <= in_rgb;
		end
	end

	// palette: write and read both happen as an item leaves stage 1, in order
	always_ff @(posedge clk) begin
		if (adv_s1 && wr_s1) begin
			palette_mem[idx_s1] <= rgb_s1;
		end
		if (adv_s1 && !wr_s1) begin
			rgb_s2 <= palette_mem[idx_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && !wr_s1) begin
			row_off_s2 <= ADDR_W'(32'(row_s1) * 32'(ROW_STRIDE));
			col2_s2    <= {col_s1, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= adv_s1 && !wr_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			pix_s3.base <= row_off_s2 + ADDR_W'(col2_s2);
			pix_s3.rgb  <= rgb_s2;
		end
	end

	ppd_expander u_expander (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix_valid     (valid_s3),
		.pix           (pix_s3),
		.pix_ready     (pix_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

`ifndef SYNTH
	a_write_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && wr_s1 |-> s_axis_tready)
		else $error("palette write stalled the input");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ready_s3 |=> valid_s2 && $stable(rgb_s2) && $stable(row_off_s2))
		else $error("stage 2 lost data under stall");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !pix_ready |=> valid_s3 && $stable(pix_s3))
		else $error("stage 3 lost data under stall");

	a_s1_pixel_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !wr_s1 && !ready_s2 |=> valid_s1 && $stable(idx_s1))
		else $error("stalled pixel in stage 1 was not held");
`endif

endmodule

// File: bench/palette_pixel_doubler_tb.sv
// Testbench for the palette pixel doubler: directed and random stream traffic with a scoreboard.
`timescale 1ns / 1ps
`default_nettype none

module palette_pixel_doubler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ppd_pkg::*;

	localparam logic MODE_PIXEL   = 1'b0;
	localparam logic MODE_PALETTE = 1'b1;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 16;
	localparam int PHASE_ITEMS = 75;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		rgb_t              rgb;
		logic              last;
	} dest_pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // column, row, color_index, red, green, blue
	logic [0:0]            s_axis_tuser = '0;  // mode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;       // dest_address, red, green, blue
	logic                  m_axis_tlast;

	rgb_t        palette_shadow [PAL_DEPTH];
	logic [7:0]  written_indexes [$];
	logic        entry_written [PAL_DEPTH];
	dest_pixel_t pixels_due [$];

	int send_idle_pct  = 0;
	int sink_stall_pct = 0;
	int error_count    = 0;
	int cycle_count    = 0;

	palette_pixel_doubler u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Update the palette copy or queue the four pixels of the 2x2 block.
	task automatic track_transfer(input logic mode, input logic [8:0] column,
			input logic [7:0] row, input logic [7:0] color_index, input rgb_t rgb);
		logic [ADDR_W-1:0] base;
		dest_pixel_t       px;
		if (mode == MODE_PALETTE) begin
			palette_shadow[color_index] = rgb;
			if (!entry_written[color_index]) begin
				entry_written[color_index] = 1'b1;
				written_indexes.push_back(color_index);
			end
		end else if (column < SRC_WIDTH && row < SRC_HEIGHT) begin
			base = ADDR_W'(2 * int'(column) + 2 * int'(row) * DST_WIDTH);
			for (int k = 0; k < 4; k++) begin
				px.addr = base + ADDR_W'((k >= 2) ? DST_WIDTH : 0) + ADDR_W'(k % 2);
				px.rgb  = palette_shadow[color_index];
				px.last = (k == 3);
				pixels_due.push_back(px);
			end
		end
	endtask

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(input logic mode, input logic [8:0] column, input logic [7:0] row,
			input logic [7:0] color_index, input rgb_t rgb);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = mode;
		s_axis_tdata  = {7'b0, rgb.blue, rgb.green, rgb.red, color_index, row, column};
		do @(posedge clk); while (!s_axis_tready);
		track_transfer(mode, column, row, color_index, rgb);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		dest_pixel_t px;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pixels_due.size() == 0) begin
				$error("output transfer with nothing expected: tdata=%h", m_axis_tdata);
				error_count++;
			end else begin
				px = pixels_due.pop_front();
				if (m_axis_tdata[17:0] !== px.addr) begin
					$error("dest_address expected %0d got %0d", px.addr, m_axis_tdata[17:0]);
					error_count++;
				end
				if (m_axis_tdata[25:18] !== px.rgb.red) begin
					$error("out_red expected %0d got %0d", px.rgb.red, m_axis_tdata[25:18]);
					error_count++;
				end
				if (m_axis_tdata[33:26] !== px.rgb.green) begin
					$error("out_green expected %0d got %0d", px.rgb.green, m_axis_tdata[33:26]);
					error_count++;
				end
				if (m_axis_tdata[41:34] !== px.rgb.blue) begin
					$error("out_blue expected %0d got %0d", px.rgb.blue, m_axis_tdata[41:34]);
					error_count++;
				end
				if (m_axis_tlast !== px.last) begin
					$error("last expected %0d got %0d", px.last, m_axis_tlast);
					error_count++;
				end
			end
		end
	end

	// Hold the input until every queued pixel has left, then let the pipe settle.
	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_entry(input logic [7:0] color_index, input logic [23:0] color);
		send_item(MODE_PALETTE, 9'($urandom_range(511)), 8'($urandom_range(255)),
			color_index, rgb_t'(color));
	endtask

	task automatic send_pixel(input int column, input int row, input logic [7:0] color_index);
		send_item(MODE_PIXEL, 9'(column), 8'(row), color_index, rgb_t'(24'($urandom)));
	endtask

	task automatic test_palette_extremes();
		write_entry(8'h00, 24'h000000);
		write_entry(8'hFF, 24'hFFFFFF);
		write_entry(8'h55, 24'hFF0055);
		write_entry(8'hAA, 24'h00FFAA);
		send_pixel(0, 0, 8'h00);
		send_pixel(1, 1, 8'hFF);
		send_pixel(2, 3, 8'h55);
		send_pixel(5, 4, 8'hAA);
	endtask

	task automatic test_frame_corners();
		send_pixel(SRC_WIDTH - 1, 0, 8'hFF);
		send_pixel(0, SRC_HEIGHT - 1, 8'h55);
		send_pixel(SRC_WIDTH - 1, SRC_HEIGHT - 1, 8'hAA);
		send_pixel(256, 128, 8'hFF);
	endtask

	// Drop pixels past the right or bottom edge, including the widest values, then send one at the last source corner.
	task automatic test_outside_source();
		send_pixel(SRC_WIDTH, 0, 8'h00);
		send_pixel(511, 10, 8'hFF);
		send_pixel(10, SRC_HEIGHT, 8'h55);
		send_pixel(0, 255, 8'hAA);
		send_pixel(511, 255, 8'h00);
		send_pixel(SRC_WIDTH - 1, SRC_HEIGHT - 1, 8'h00);
	endtask

	// Overwrite an entry and read it back on the very next transfer.
	task automatic test_write_then_read();
		write_entry(8'h00, 24'h123456);
		send_pixel(7, 9, 8'h00);
		write_entry(8'hFF, 24'hA5C3E1);
		send_pixel(100, 150, 8'hFF);
		write_entry(8'h00, 24'hFEDCBA);
		send_pixel(100, 151, 8'h00);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		int pick;
		send_idle_pct  = idle_pct;
		sink_stall_pct = stall_pct;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				write_entry(8'($urandom_range(255)), 24'($urandom));
			end else if (pick < 30) begin
				case ($urandom_range(2))
					0:       send_pixel($urandom_range(511, SRC_WIDTH),
							$urandom_range(SRC_HEIGHT - 1),
							written_indexes[$urandom_range(written_indexes.size() - 1)]);
					1:       send_pixel($urandom_range(SRC_WIDTH - 1),
							$urandom_range(255, SRC_HEIGHT),
							written_indexes[$urandom_range(written_indexes.size() - 1)]);
					default: send_pixel($urandom_range(511, SRC_WIDTH),
							$urandom_range(255, SRC_HEIGHT),
							written_indexes[$urandom_range(written_indexes.size() - 1)]);
				endcase
			end else begin
				send_pixel($urandom_range(SRC_WIDTH - 1), $urandom_range(SRC_HEIGHT - 1),
					written_indexes[$urandom_range(written_indexes.size() - 1)]);
			end
		end
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < PAL_DEPTH; i++) entry_written[i] = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_palette_extremes();
		test_frame_corners();
		test_outside_source();
		test_write_then_read();
		wait_drained();

		test_random_traffic(0, 0);
		test_random_traffic(55, 0);
		test_random_traffic(0, 55);
		test_random_traffic(35, 35);

		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: palette_pixel_doubler.f
hw/rtl/ppd_pkg.sv
hw/rtl/ppd_expander.sv
hw/rtl/palette_pixel_doubler.sv
bench/palette_pixel_doubler_tb.sv
